>>> rtl/dts_pkg.sv
// Shared types and constants for the dependency task scheduler.
package dts_pkg;

    localparam int DEP_FIELDS = 4;

    typedef enum logic [1:0] {
        ACT_ADD  = 2'd0,
        ACT_TAKE = 2'd1,
        ACT_DONE = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOREADY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD,
        S_T_RD,
        S_T_CHK,
        S_L_RD,
        S_L_WR,
        S_C_RD,
        S_C_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    in_ready;
        logic    idx_clr;
        logic    idx_inc;
        logic    rd_last;
        logic    add_wr;
        logic    cap_found;
        logic    move_wr;
        logic    clr_wr;
        logic    set_status;
        t_status status;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic    in_valid;
        t_action action;
        logic    full;
        logic    done_zero;
        logic    idx_end;
        logic    ready_hit;
        logic    out_free;
    } t_stat;

endpackage

>>> rtl/dts_if.sv
// Input and result channel interfaces of the task scheduler.
interface dts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] task_handle;
    logic [2:0]  dep_count;
    logic [15:0] dep_tid_0;
    logic [15:0] dep_tid_1;
    logic [15:0] dep_tid_2;
    logic [15:0] dep_tid_3;
    logic [15:0] done_tid;
    modport source (output valid, action, task_handle, dep_count, dep_tid_0, dep_tid_1,
                    dep_tid_2, dep_tid_3, done_tid, input ready);
    modport sink (input valid, action, task_handle, dep_count, dep_tid_0, dep_tid_1,
                  dep_tid_2, dep_tid_3, done_tid, output ready);
endinterface

interface dts_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] result_tid;
    logic [15:0] result_handle;
    logic [4:0]  task_count;
    modport source (output valid, status, result_tid, result_handle, task_count,
                    input ready);
    modport sink (input valid, status, result_tid, result_handle, task_count,
                  output ready);
endinterface

>>> rtl/dts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/dts_ctrl.sv
// Controller state machine of the task scheduler.
module dts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dts_pkg::t_stat i_stat,
    output dts_pkg::t_cmd  o_cmd
);
    import dts_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (i_stat.action)
                    ACT_ADD: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status = ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_ADD;
                        end
                    end
                    ACT_TAKE: begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = S_T_RD;
                    end
                    ACT_DONE: begin
                        o_cmd.idx_clr = 1'b1;
                        n_state = i_stat.done_zero ? S_DONE : S_C_RD;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_ADD: begin
                o_cmd.add_wr = 1'b1;
                n_state = S_DONE;
            end
            S_T_RD: begin
                if (i_stat.idx_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status = ST_NOREADY;
                    n_state = S_DONE;
                end else begin
                    n_state = S_T_CHK;
                end
            end
            S_T_CHK: begin
                if (i_stat.ready_hit) begin
                    o_cmd.cap_found = 1'b1;
                    n_state = S_L_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_T_RD;
                end
            end
            S_L_RD: begin
                o_cmd.rd_last = 1'b1;
                n_state = S_L_WR;
            end
            S_L_WR: begin
                o_cmd.move_wr = 1'b1;
                n_state = S_DONE;
            end
            S_C_RD: begin
                n_state = i_stat.idx_end ? S_DONE : S_C_CHK;
            end
            S_C_CHK: begin
                o_cmd.clr_wr = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state = S_C_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> rtl/dts_dp.sv
// Datapath of the task scheduler: task table, counters and result register.
module dts_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int MAX_DEPS    = 4,
    parameter int TID_BITS    = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dts_pkg::t_cmd  i_cmd,
    output dts_pkg::t_stat o_stat,
    dts_in_if.sink         i_task,
    dts_out_if.source      o_res
);
    import dts_pkg::*;

    localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int DOFF = MAX_DEPS;
    localparam int HOFF = DOFF + MAX_DEPS * TID_BITS;
    localparam int TOFF = HOFF + HANDLE_BITS;
    localparam int W    = TOFF + TID_BITS;

    logic [1:0]             r_act;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [2:0]             r_n;
    logic [TID_BITS-1:0]    r_dep [MAX_DEPS];
    logic [TID_BITS-1:0]    r_done;
    logic [CW-1:0]          r_idx;
    logic [CW-1:0]          r_count;
    logic [TID_BITS-1:0]    r_last_tid;
    logic [TID_BITS-1:0]    r_res_tid;
    logic [HANDLE_BITS-1:0] r_res_handle;
    t_status                r_status;
    logic                   r_ov;
    logic [1:0]             r_o_status;
    logic [15:0]            r_o_tid;
    logic [15:0]            r_o_handle;
    logic [4:0]             r_o_count;

    logic [TID_BITS-1:0] in_dep [DEP_FIELDS];
    logic [TID_BITS-1:0] nt;
    logic [3:0]          lim;
    logic [MAX_DEPS-1:0] keep;
    logic [MAX_DEPS-1:0] clr_valid;
    logic [W-1:0]        new_word;
    logic [W-1:0]        rdata;
    logic [W-1:0]        wdata;
    logic [IW-1:0]       waddr;
    logic [IW-1:0]       raddr;
    logic [CW-1:0]       last_idx;
    logic                we;
    logic                accept;

    assign in_dep[0] = TID_BITS'(i_task.dep_tid_0);
    assign in_dep[1] = TID_BITS'(i_task.dep_tid_1);
    assign in_dep[2] = TID_BITS'(i_task.dep_tid_2);
    assign in_dep[3] = TID_BITS'(i_task.dep_tid_3);

    assign accept = i_task.valid && i_cmd.in_ready;
    assign i_task.ready = i_cmd.in_ready;

    always_comb begin
        nt = r_last_tid + 1'b1;
        if (nt == '0) nt = TID_BITS'(1);
        lim = {1'b0, r_n};
        if (lim > 4'(DEP_FIELDS)) lim = 4'(DEP_FIELDS);
        if (lim > 4'(MAX_DEPS)) lim = 4'(MAX_DEPS);
        keep = '0;
        for (int i = 0; i < MAX_DEPS; i++) begin
            keep[i] = (4'(i) < lim);
            for (int k = 0; k < MAX_DEPS; k++) begin
                if (k < i && keep[k] && r_dep[k] == r_dep[i]) keep[i] = 1'b0;
            end
        end
        new_word = '0;
        new_word[TOFF +: TID_BITS] = nt;
        new_word[HOFF +: HANDLE_BITS] = r_handle;
        for (int i = 0; i < MAX_DEPS; i++) begin
            new_word[DOFF + i*TID_BITS +: TID_BITS] = r_dep[i];
        end
        new_word[MAX_DEPS-1:0] = keep;
        clr_valid = rdata[MAX_DEPS-1:0];
        for (int k = 0; k < MAX_DEPS; k++) begin
            if (rdata[DOFF + k*TID_BITS +: TID_BITS] == r_done) clr_valid[k] = 1'b0;
        end
    end

    assign last_idx = r_count - 1'b1;
    assign raddr = i_cmd.rd_last ? last_idx[IW-1:0] : r_idx[IW-1:0];
    assign we = i_cmd.add_wr || i_cmd.move_wr || i_cmd.clr_wr;
    assign waddr = i_cmd.add_wr ? r_count[IW-1:0] : r_idx[IW-1:0];

    always_comb begin
        wdata = rdata;
        if (i_cmd.add_wr) begin
            wdata = new_word;
        end else if (i_cmd.clr_wr) begin
            wdata[MAX_DEPS-1:0] = clr_valid;
        end
    end

    dts_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act    <= i_task.action;
            r_handle <= HANDLE_BITS'(i_task.task_handle);
            r_n      <= i_task.dep_count;
            r_done   <= TID_BITS'(i_task.done_tid);
            for (int i = 0; i < MAX_DEPS; i++) begin
                r_dep[i] <= (i < DEP_FIELDS) ? in_dep[i % DEP_FIELDS] : '0;
            end
            r_res_tid    <= '0;
            r_res_handle <= '0;
            r_status     <= ST_OK;
        end else begin
            if (i_cmd.set_status) r_status <= i_cmd.status;
            if (i_cmd.add_wr) r_res_tid <= nt;
            if (i_cmd.cap_found) begin
                r_res_tid    <= rdata[TOFF +: TID_BITS];
                r_res_handle <= rdata[HOFF +: HANDLE_BITS];
            end
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_tid    <= 16'(r_res_tid);
            r_o_handle <= 16'(r_res_handle);
            r_o_count  <= 5'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_last_tid <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cmd.add_wr) begin
                r_count    <= r_count + 1'b1;
                r_last_tid <= nt;
            end else if (i_cmd.move_wr) begin
                r_count <= last_idx;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_stat.in_valid  = i_task.valid;
    assign o_stat.action    = t_action'(r_act);
    assign o_stat.full      = (r_count == CW'(TABLE_DEPTH));
    assign o_stat.done_zero = (r_done == '0);
    assign o_stat.idx_end   = (r_idx == r_count);
    assign o_stat.ready_hit = (rdata[MAX_DEPS-1:0] == '0);
    assign o_stat.out_free  = !r_ov || o_res.ready;

    assign o_res.valid         = r_ov;
    assign o_res.status        = r_o_status;
    assign o_res.result_tid    = r_o_tid;
    assign o_res.result_handle = r_o_handle;
    assign o_res.task_count    = r_o_count;
endmodule

>>> rtl/dependency_task_scheduler.sv
// One word in process at a time; the table sweep through the single RAM read port
// sets the time for take and completion words.
// The result register lets the next word be accepted while a result waits.
// Synchronous active-low reset clears the task count, ID counter and result valid.
module dependency_task_scheduler #(
    parameter int TABLE_DEPTH = 16,
    parameter int MAX_DEPS    = 4,
    parameter int TID_BITS    = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dts_in_if.sink    i_task,
    dts_out_if.source o_res
);
    import dts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_DEPS    (MAX_DEPS),
        .TID_BITS    (TID_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_task  (i_task),
        .o_res   (o_res)
    );
endmodule

>>> rtl/dts_checker.sv
// Port-level assertions for the task scheduler, bound to the top level.
module dts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [15:0] i_result_tid,
    input logic [15:0] i_result_handle
);
    import dts_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_FULL || i_status == ST_NOREADY))
        else $error("undefined status code");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_FULL) |-> (i_result_tid == '0 && i_result_handle == '0))
        else $error("full status with nonzero result");

    a_noready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_NOREADY)
            |-> (i_result_tid == '0 && i_result_handle == '0))
        else $error("no-ready status with nonzero result");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind dependency_task_scheduler dts_checker u_dts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_status        (o_res.status),
    .i_result_tid    (o_res.result_tid),
    .i_result_handle (o_res.result_handle)
);

>>> tb/sv/dependency_task_scheduler_tb.sv
// Self-checking testbench for the dependency task scheduler: directed and random words.
`timescale 1ns / 100ps

module dependency_task_scheduler_tb;
    import dts_pkg::*;

    localparam int DEPTH = 16;
    localparam int NDEP = 4;
    localparam int LIMIT = 400000;

    typedef struct packed {
        t_action     action;
        logic [15:0] task_handle;
        logic [2:0]  dep_count;
        logic [15:0] dep0;
        logic [15:0] dep1;
        logic [15:0] dep2;
        logic [15:0] dep3;
        logic [15:0] done_tid;
    } t_word;

    typedef struct packed {
        t_status     status;
        logic [15:0] tid;
        logic [15:0] handle;
        logic [4:0]  count;
    } t_result;

    class sched_scoreboard;
        logic [15:0] tid_tab [DEPTH];
        logic [15:0] hnd_tab [DEPTH];
        logic [15:0] dep_tab [DEPTH][NDEP];
        logic [3:0]  dv_tab  [DEPTH];
        int unsigned count;
        logic [15:0] last_tid;
        t_result     pending [$];
        int          errors;

        function new();
            count = 0;
            last_tid = 0;
            errors = 0;
        endfunction

        function void note_word(t_word w);
            t_result r;
            logic [15:0] d [NDEP];
            logic [15:0] nt;
            int n, i, k, s;
            bit dup, found;
            r = '0;
            r.status = ST_OK;
            d[0] = w.dep0; d[1] = w.dep1; d[2] = w.dep2; d[3] = w.dep3;
            case (w.action)
                ACT_ADD: begin
                    if (count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        s = count;
                        nt = last_tid + 16'd1;
                        if (nt == 16'd0) nt = 16'd1;
                        last_tid = nt;
                        n = (w.dep_count > NDEP) ? NDEP : w.dep_count;
                        tid_tab[s] = nt;
                        hnd_tab[s] = w.task_handle;
                        dv_tab[s] = 4'd0;
                        for (i = 0; i < n; i++) begin
                            dup = 0;
                            for (k = 0; k < NDEP; k++)
                                if (dv_tab[s][k] && dep_tab[s][k] == d[i]) dup = 1;
                            if (!dup) begin
                                dep_tab[s][i] = d[i];
                                dv_tab[s][i] = 1'b1;
                            end
                        end
                        count = s + 1;
                        r.tid = nt;
                    end
                end
                ACT_TAKE: begin
                    found = 0;
                    for (i = 0; i < count; i++)
                        if (!found && dv_tab[i] == 4'd0) begin
                            found = 1;
                            s = i;
                        end
                    if (found) begin
                        r.tid = tid_tab[s];
                        r.handle = hnd_tab[s];
                        tid_tab[s] = tid_tab[count-1];
                        hnd_tab[s] = hnd_tab[count-1];
                        dv_tab[s] = dv_tab[count-1];
                        for (k = 0; k < NDEP; k++) dep_tab[s][k] = dep_tab[count-1][k];
                        count--;
                    end else begin
                        r.status = ST_NOREADY;
                    end
                end
                ACT_DONE: begin
                    if (w.done_tid != 16'd0)
                        for (i = 0; i < count; i++)
                            for (k = 0; k < NDEP; k++)
                                if (dv_tab[i][k] && dep_tab[i][k] == w.done_tid)
                                    dv_tab[i][k] = 1'b0;
                end
                default: ;
            endcase
            r.count = 5'(count);
            pending = {pending, r};
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected st=%0d tid=%h hnd=%h cnt=%0d, ",
                              "got st=%0d tid=%h hnd=%h cnt=%0d"},
                             e.status, e.tid, e.handle, e.count,
                             got.status, got.tid, got.handle, got.count);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    int unsigned cycles = 0;
    bit calm = 0;
    sched_scoreboard board;

    dts_in_if  task_ch();
    dts_out_if res_ch();

    dependency_task_scheduler dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_task (task_ch.sink),
        .o_res  (res_ch.source)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result sink with random stall bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check_result({t_status'(res_ch.status), res_ch.result_tid,
                                res_ch.result_handle, res_ch.task_count});
        if (!calm && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 3);
        if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 0;
        end else begin
            res_ch.ready <= i_rst_n;
        end
    end

    task automatic send_word(t_word w);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            task_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        task_ch.valid <= 1;
        task_ch.action <= w.action;
        task_ch.task_handle <= w.task_handle;
        task_ch.dep_count <= w.dep_count;
        task_ch.dep_tid_0 <= w.dep0;
        task_ch.dep_tid_1 <= w.dep1;
        task_ch.dep_tid_2 <= w.dep2;
        task_ch.dep_tid_3 <= w.dep3;
        task_ch.done_tid <= w.done_tid;
        do @(posedge i_clk); while (!task_ch.ready);
        board.note_word(w);
    endtask

    task automatic drain();
        task_ch.valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_word make_word(t_action a, logic [15:0] h, logic [2:0] n,
                                        logic [15:0] d0, logic [15:0] d1,
                                        logic [15:0] d2, logic [15:0] d3,
                                        logic [15:0] fin);
        t_word w;
        w.action = a; w.task_handle = h; w.dep_count = n;
        w.dep0 = d0; w.dep1 = d1; w.dep2 = d2; w.dep3 = d3; w.done_tid = fin;
        return w;
    endfunction

    // dependencies mostly point at recently issued IDs so tasks unblock
    function automatic logic [15:0] near_tid();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return 16'd0;
        return board.last_tid - 16'($urandom_range(0, 6)) + 16'($urandom_range(0, 2));
    endfunction

    function automatic t_word rand_word();
        t_word w;
        int r;
        w = '0;
        w.task_handle = 16'($urandom);
        w.dep_count = 3'($urandom_range(0, 7));
        w.dep0 = near_tid(); w.dep1 = near_tid();
        w.dep2 = near_tid(); w.dep3 = near_tid();
        w.done_tid = near_tid();
        r = $urandom_range(0, 99);
        if (r < 38) w.action = ACT_ADD;
        else if (r < 68) w.action = ACT_TAKE;
        else if (r < 97) w.action = ACT_DONE;
        else w.action = ACT_NOP;
        if ($urandom_range(0, 3) == 0) w.dep_count = 3'($urandom_range(0, 1));
        if (w.action != ACT_ADD && $urandom_range(0, 1)) begin
            w.task_handle = 16'($urandom);
            w.dep0 = 16'($urandom); w.dep1 = 16'($urandom);
            w.dep2 = 16'($urandom); w.dep3 = 16'($urandom);
        end
        return w;
    endfunction

    int i;
    initial begin
        task_ch.valid = 0;
        task_ch.action = ACT_NOP;
        task_ch.task_handle = 0;
        task_ch.dep_count = 0;
        task_ch.dep_tid_0 = 0;
        task_ch.dep_tid_1 = 0;
        task_ch.dep_tid_2 = 0;
        task_ch.dep_tid_3 = 0;
        task_ch.done_tid = 0;
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: empty take, zero completion, nop, duplicates, zero and unknown deps
        send_word(make_word(ACT_TAKE, 16'hFFFF, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF));
        send_word(make_word(ACT_DONE, 16'hFFFF, 7, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_NOP, 16'hFFFF, 7, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF, 16'hFFFF));
        send_word(make_word(ACT_ADD, 16'h0000, 0, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_ADD, 16'hFFFF, 7, 1, 1, 16'hFFFF, 1, 0));
        send_word(make_word(ACT_ADD, 16'hA5A5, 4, 0, 2, 2, 16'h1234, 0));
        send_word(make_word(ACT_ADD, 16'h5A5A, 3, 16'h0003, 16'h0002, 16'h0001, 0, 0));
        send_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_DONE, 0, 0, 0, 0, 0, 0, 16'd1));
        send_word(make_word(ACT_DONE, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        send_word(make_word(ACT_DONE, 0, 0, 0, 0, 0, 0, 16'd2));
        send_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(ACT_DONE, 0, 0, 0, 0, 0, 0, 16'd3));
        send_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 0));
        // fill the table past full
        for (i = 0; i < 18; i++)
            send_word(make_word(ACT_ADD, 16'($urandom), 0, 0, 0, 0, 0, 0));
        drain();
        for (i = 0; i < 17; i++)
            send_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 0));
        // alternate adds and takes on an almost empty table
        for (i = 0; i < 40; i++) begin
            if (i % 2 == 0)
                send_word(make_word(ACT_ADD, 16'($urandom), 0, 0, 0, 0, 0, 0));
            else
                send_word(make_word(ACT_TAKE, 0, 0, 0, 0, 0, 0, 0));
        end
        drain();
        for (i = 0; i < 500; i++) begin
            if (i == 250) drain();
            if (i == 450) calm = 1;
            send_word(rand_word());
        end
        drain();
        repeat (100) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
